@@ src/sstq_pkg.sv @@
`default_nettype none

package sstq_pkg;

    localparam int MAX_ENTRIES_DEF = 1024;
    localparam int VALUE_W = 32;
    localparam int POS_W = 11;

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0]                opcode;
        logic signed [VALUE_W-1:0] load_value;
        logic signed [VALUE_W-1:0] low_key;
        logic signed [VALUE_W-1:0] high_key;
    } in_word_t;

    typedef struct packed {
        logic             low_found;
        logic [POS_W-1:0] low_position;
        logic             high_found;
        logic [POS_W-1:0] high_position;
        logic [POS_W-1:0] distinct_in_range;
    } out_word_t;

    typedef struct packed {
        logic lt_low;
        logic lt_high;
        logic eq_low;
        logic eq_high;
        logic new_distinct;
    } cell_flags_t;

endpackage

`default_nettype wire

@@ src/sstq_cell.sv @@
`default_nettype none

module sstq_cell
(
    input  wire logic                                 clk,
    input  wire logic                                 head,
    input  wire logic                                 occupied,
    input  wire logic                                 open_slot,
    input  wire logic                                 load_en,
    input  wire logic signed [sstq_pkg::VALUE_W-1:0]  load_value,
    input  wire logic signed [sstq_pkg::VALUE_W-1:0]  left_value,
    input  wire logic                                 left_shift,
    input  wire logic                                 capture,
    input  wire logic signed [sstq_pkg::VALUE_W-1:0]  key_low,
    input  wire logic signed [sstq_pkg::VALUE_W-1:0]  key_high,
    output logic signed [sstq_pkg::VALUE_W-1:0]       value,
    output logic                                      shift,
    output sstq_pkg::cell_flags_t                     flags
);

    logic signed [sstq_pkg::VALUE_W-1:0] value_reg;
    sstq_pkg::cell_flags_t               flags_reg;
    sstq_pkg::cell_flags_t               flags_next;

    assign shift = occupied && (value_reg > load_value);
    assign value = value_reg;
    assign flags = flags_reg;

    always_comb
    begin
        flags_next.lt_low = occupied && (value_reg < key_low);
        flags_next.lt_high = occupied && (value_reg < key_high);
        flags_next.eq_low = occupied && (value_reg == key_low);
        flags_next.eq_high = occupied && (value_reg == key_high);
        flags_next.new_distinct = occupied && !(value_reg < key_low)
            && (value_reg < key_high) && (head || (value_reg != left_value));
    end

    always_ff @(posedge clk)
    begin
        if (load_en && (shift || open_slot))
        begin
            value_reg <= left_shift ? left_value : load_value;
        end
        if (capture)
        begin
            flags_reg <= flags_next;
        end
    end

endmodule

`default_nettype wire

@@ src/sstq_count.sv @@
`default_nettype none

module sstq_count
#(
    parameter int N  = sstq_pkg::MAX_ENTRIES_DEF,
    parameter int CW = $clog2(N + 1)
)
(
    input  wire logic          clk,
    input  wire logic [N-1:0]  leaves,
    output logic [CW-1:0]      total
);

    localparam int LOG = $clog2(N);
    localparam int P = 1 << LOG;

    logic [P-1:0]  leaf_pad;
    logic [CW-1:0] sum_reg [1:P-1];

    assign leaf_pad = P'(leaves);
    assign total = sum_reg[1];

    for (genvar k = 1; k < P; k++)
    begin : g_node
        if (2 * k >= P)
        begin : g_bottom
            always_ff @(posedge clk)
            begin
                sum_reg[k] <= CW'(leaf_pad[2*k-P]) + CW'(leaf_pad[2*k+1-P]);
            end
        end
        else
        begin : g_inner
            always_ff @(posedge clk)
            begin
                sum_reg[k] <= sum_reg[2*k] + sum_reg[2*k+1];
            end
        end
    end

endmodule

`default_nettype wire

@@ src/sorted_store_range_query.sv @@
// Loads into a store that is not full and clears take effect at the edge that accepts them.
// A query stalls the input until its result word is registered: the per-cell flags are
// captured, pipelined counting trees sum them, and the result waits while an earlier
// result is still stalled at the output.
// Reset empties the store and clears the control state and the output valid; the cell
// values themselves are not reset.
`default_nettype none

module sorted_store_range_query
#(
    parameter int MAX_ENTRIES = sstq_pkg::MAX_ENTRIES_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire sstq_pkg::in_word_t   in_word,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output sstq_pkg::out_word_t       out_word
);

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int SUM_LAT = $clog2(MAX_ENTRIES);
    localparam int TMR_W = $clog2(SUM_LAT + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CAPTURE,
        S_SUM,
        S_DONE
    } state_t;

    state_t                              state_reg;
    logic [CNT_W-1:0]                    count_reg;
    logic [TMR_W-1:0]                    timer_reg;
    logic signed [sstq_pkg::VALUE_W-1:0] key_low_reg;
    logic signed [sstq_pkg::VALUE_W-1:0] key_high_reg;
    logic                                out_valid_reg;
    sstq_pkg::out_word_t                 out_word_reg;

    logic                                in_take;
    logic                                full;
    logic                                load_en;
    logic                                capture;

    logic signed [sstq_pkg::VALUE_W-1:0] cell_value [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0]              cell_shift;
    sstq_pkg::cell_flags_t               cell_flags [MAX_ENTRIES];

    logic [MAX_ENTRIES-1:0]              lt_low_vec;
    logic [MAX_ENTRIES-1:0]              lt_high_vec;
    logic [MAX_ENTRIES-1:0]              eq_low_vec;
    logic [MAX_ENTRIES-1:0]              eq_high_vec;
    logic [MAX_ENTRIES-1:0]              distinct_vec;

    logic [CNT_W-1:0]                    lt_low_cnt;
    logic [CNT_W-1:0]                    lt_high_cnt;
    logic [CNT_W-1:0]                    eq_low_cnt;
    logic [CNT_W-1:0]                    eq_high_cnt;
    logic [CNT_W-1:0]                    distinct_cnt;

    assign in_stall = (state_reg != S_IDLE);
    assign in_take = in_valid && !in_stall;
    assign full = (count_reg == CNT_W'(MAX_ENTRIES));
    assign load_en = in_take && (in_word.opcode == sstq_pkg::OP_LOAD) && !full;
    assign capture = (state_reg == S_CAPTURE);
    assign out_valid = out_valid_reg;
    assign out_word = out_word_reg;

    for (genvar i = 0; i < MAX_ENTRIES; i++)
    begin : g_cell
        logic signed [sstq_pkg::VALUE_W-1:0] left_value;
        logic                                left_shift;

        if (i == 0)
        begin : g_head
            assign left_value = cell_value[0];
            assign left_shift = 1'b0;
        end
        else
        begin : g_body
            assign left_value = cell_value[i-1];
            assign left_shift = cell_shift[i-1];
        end

        sstq_cell u_cell
        (
            .clk        (clk),
            .head       (i == 0),
            .occupied   (CNT_W'(i) < count_reg),
            .open_slot  (CNT_W'(i) == count_reg),
            .load_en    (load_en),
            .load_value (in_word.load_value),
            .left_value (left_value),
            .left_shift (left_shift),
            .capture    (capture),
            .key_low    (key_low_reg),
            .key_high   (key_high_reg),
            .value      (cell_value[i]),
            .shift      (cell_shift[i]),
            .flags      (cell_flags[i])
        );

        assign lt_low_vec[i] = cell_flags[i].lt_low;
        assign lt_high_vec[i] = cell_flags[i].lt_high;
        assign eq_low_vec[i] = cell_flags[i].eq_low;
        assign eq_high_vec[i] = cell_flags[i].eq_high;
        assign distinct_vec[i] = cell_flags[i].new_distinct;
    end

    sstq_count #(.N(MAX_ENTRIES), .CW(CNT_W)) u_cnt_lt_low
    (
        .clk    (clk),
        .leaves (lt_low_vec),
        .total  (lt_low_cnt)
    );

    sstq_count #(.N(MAX_ENTRIES), .CW(CNT_W)) u_cnt_lt_high
    (
        .clk    (clk),
        .leaves (lt_high_vec),
        .total  (lt_high_cnt)
    );

    sstq_count #(.N(MAX_ENTRIES), .CW(CNT_W)) u_cnt_eq_low
    (
        .clk    (clk),
        .leaves (eq_low_vec),
        .total  (eq_low_cnt)
    );

    sstq_count #(.N(MAX_ENTRIES), .CW(CNT_W)) u_cnt_eq_high
    (
        .clk    (clk),
        .leaves (eq_high_vec),
        .total  (eq_high_cnt)
    );

    sstq_count #(.N(MAX_ENTRIES), .CW(CNT_W)) u_cnt_distinct
    (
        .clk    (clk),
        .leaves (distinct_vec),
        .total  (distinct_cnt)
    );

    always_ff @(posedge clk)
    begin
        if (in_take && (in_word.opcode == sstq_pkg::OP_QUERY))
        begin
            key_low_reg <= in_word.low_key;
            key_high_reg <= in_word.high_key;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            timer_reg <= '0;
            out_valid_reg <= 1'b0;
            out_word_reg <= '0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_take)
                    begin
                        case (in_word.opcode)
                            sstq_pkg::OP_LOAD:
                            begin
                                if (!full)
                                begin
                                    count_reg <= count_reg + 1'b1;
                                end
                            end
                            sstq_pkg::OP_CLEAR:
                            begin
                                count_reg <= '0;
                            end
                            sstq_pkg::OP_QUERY:
                            begin
                                state_reg <= S_CAPTURE;
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_CAPTURE:
                begin
                    timer_reg <= TMR_W'(SUM_LAT);
                    state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    timer_reg <= timer_reg - 1'b1;
                    if (timer_reg == TMR_W'(1))
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        out_word_reg.low_found <= (eq_low_cnt != '0);
                        out_word_reg.low_position <=
                            sstq_pkg::POS_W'(lt_low_cnt) + sstq_pkg::POS_W'(1);
                        out_word_reg.high_found <= (eq_high_cnt != '0);
                        out_word_reg.high_position <=
                            sstq_pkg::POS_W'(lt_high_cnt) + sstq_pkg::POS_W'(1);
                        out_word_reg.distinct_in_range <= sstq_pkg::POS_W'(distinct_cnt);
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ tb/tb_sorted_store_range_query.sv @@
`default_nettype none

module tb_sorted_store_range_query;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic signed [31:0] KEY_MIN = 32'sh80000000;
    localparam logic signed [31:0] KEY_MAX = 32'sh7fffffff;
    localparam int HOLD_CYCLES = 400;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    sstq_pkg::in_word_t in_word = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    sstq_pkg::out_word_t out_word;

    sstq_pkg::in_word_t pending_words[$];
    sstq_pkg::out_word_t expected_answers[$];
    logic signed [31:0] gen_values[$];

    logic signed [31:0] model_values [0:sstq_pkg::MAX_ENTRIES_DEF-1];
    int model_count = 0;

    bit in_accepted = 1'b0;
    bit quiet = 1'b0;
    int gap_left = 0;
    int hold_requests = 0;
    int holds_served = 0;
    int hold_left = 0;
    int burst_left = 0;
    bit burst_stall = 1'b0;
    int mismatches = 0;

    sorted_store_range_query dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_word(in_word),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_word(out_word)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int count_below(logic signed [31:0] key);
        int n;
        int k;
        n = 0;
        for (k = 0; k < model_count; k++)
        begin
            if ($signed(model_values[k]) < key)
                n++;
        end
        return n;
    endfunction

    task automatic apply_word(sstq_pkg::in_word_t w);
        int pos;
        int li;
        int hi;
        int distinct;
        int k;
        sstq_pkg::out_word_t r;
        case (w.opcode)
            sstq_pkg::OP_LOAD:
            begin
                if (model_count < sstq_pkg::MAX_ENTRIES_DEF)
                begin
                    pos = model_count;
                    while (pos > 0 && $signed(model_values[pos-1]) > $signed(w.load_value))
                    begin
                        model_values[pos] = model_values[pos-1];
                        pos--;
                    end
                    model_values[pos] = w.load_value;
                    model_count++;
                end
            end
            sstq_pkg::OP_QUERY:
            begin
                li = count_below($signed(w.low_key));
                hi = count_below($signed(w.high_key));
                distinct = 0;
                if (li < hi)
                begin
                    distinct = 1;
                    for (k = li + 1; k < hi; k++)
                    begin
                        if (model_values[k] != model_values[k-1])
                            distinct++;
                    end
                end
                r.low_found = (li < model_count) && (model_values[li] == w.low_key);
                r.high_found = (hi < model_count) && (model_values[hi] == w.high_key);
                r.low_position = sstq_pkg::POS_W'(li + 1);
                r.high_position = sstq_pkg::POS_W'(hi + 1);
                r.distinct_in_range = sstq_pkg::POS_W'(distinct);
                expected_answers.push_back(r);
            end
            sstq_pkg::OP_CLEAR:
            begin
                model_count = 0;
            end
            default:
            begin
            end
        endcase
    endtask

    function automatic logic signed [31:0] pick_value();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 5)
            return int'($urandom_range(0, 80)) - 40;
        if (sel < 7)
            return $urandom;
        if (sel == 7)
            return $urandom_range(0, 1) ? KEY_MAX - int'($urandom_range(0, 1))
                                        : KEY_MIN + int'($urandom_range(0, 1));
        if (sel == 8 && gen_values.size() > 0)
            return gen_values[$urandom_range(0, gen_values.size() - 1)];
        return int'($urandom_range(0, 2000)) - 1000;
    endfunction

    function automatic logic signed [31:0] pick_key();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4 && gen_values.size() > 0)
            return gen_values[$urandom_range(0, gen_values.size() - 1)];
        if (sel == 4 && gen_values.size() > 0)
            return gen_values[$urandom_range(0, gen_values.size() - 1)]
                   + int'($urandom_range(0, 2)) - 1;
        if (sel == 5)
            return $urandom;
        if (sel == 6)
            return $urandom_range(0, 1) ? KEY_MAX : KEY_MIN;
        return int'($urandom_range(0, 80)) - 40;
    endfunction

    task automatic push_load(logic signed [31:0] v);
        sstq_pkg::in_word_t w;
        w.opcode = sstq_pkg::OP_LOAD;
        w.load_value = v;
        w.low_key = $urandom;
        w.high_key = $urandom;
        pending_words.push_back(w);
        if (gen_values.size() < sstq_pkg::MAX_ENTRIES_DEF)
            gen_values.push_back(v);
    endtask

    task automatic push_query(logic signed [31:0] lk, logic signed [31:0] hk);
        sstq_pkg::in_word_t w;
        w.opcode = sstq_pkg::OP_QUERY;
        w.load_value = $urandom;
        w.low_key = lk;
        w.high_key = hk;
        pending_words.push_back(w);
    endtask

    task automatic push_other(logic [1:0] op);
        sstq_pkg::in_word_t w;
        w.opcode = op;
        w.load_value = $urandom;
        w.low_key = $urandom;
        w.high_key = $urandom;
        pending_words.push_back(w);
        if (op == sstq_pkg::OP_CLEAR)
            gen_values.delete();
    endtask

    task automatic push_random_items(int n);
        int sel;
        repeat (n)
        begin
            sel = $urandom_range(0, 999);
            if (sel < 420)
                push_load(pick_value());
            else if (sel < 920)
                push_query(pick_key(), pick_key());
            else if (sel < 925)
                push_other(sstq_pkg::OP_CLEAR);
            else if (sel < 945)
                push_other(OP_UNUSED);
            else
                push_query($urandom, $urandom);
        end
    endtask

    task automatic wait_drained();
        while (pending_words.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_answers.size() != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_accepted)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (pending_words.size() == 0)
                in_valid <= 1'b0;
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                gap_left = $urandom_range(0, 12);
                in_valid <= 1'b0;
            end
            else
            begin
                in_word <= pending_words.pop_front();
                in_valid <= 1'b1;
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (holds_served != hold_requests)
        begin
            holds_served++;
            hold_left = HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end
        else if (quiet)
            out_stall <= 1'b0;
        else
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 13);
                burst_stall = ($urandom_range(0, 2) == 0);
            end
            burst_left--;
            out_stall <= burst_stall;
        end
    end

    always @(posedge clk)
    begin : monitor
        sstq_pkg::out_word_t want;
        in_accepted = rst_n && in_valid && !in_stall;
        if (in_accepted)
            apply_word(in_word);
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_answers.size() == 0)
            begin
                $error("result word with no query waiting");
                mismatches++;
            end
            else
            begin
                want = expected_answers.pop_front();
                if (out_word.low_found !== want.low_found)
                begin
                    $error("low_found: expected %0d, got %0d", want.low_found,
                           out_word.low_found);
                    mismatches++;
                end
                if (out_word.low_position !== want.low_position)
                begin
                    $error("low_position: expected %0d, got %0d", want.low_position,
                           out_word.low_position);
                    mismatches++;
                end
                if (out_word.high_found !== want.high_found)
                begin
                    $error("high_found: expected %0d, got %0d", want.high_found,
                           out_word.high_found);
                    mismatches++;
                end
                if (out_word.high_position !== want.high_position)
                begin
                    $error("high_position: expected %0d, got %0d", want.high_position,
                           out_word.high_position);
                    mismatches++;
                end
                if (out_word.distinct_in_range !== want.distinct_in_range)
                begin
                    $error("distinct_in_range: expected %0d, got %0d",
                           want.distinct_in_range, out_word.distinct_in_range);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The empty store, the signed extremes, duplicates, odd key pairs, an unused opcode and a clear.
        push_query(0, 0);
        push_query(KEY_MIN, KEY_MAX);
        push_load(KEY_MAX);
        push_load(KEY_MIN);
        push_load(0);
        push_load(-1);
        push_load(5);
        push_load(5);
        push_load(5);
        push_load(7);
        push_other(OP_UNUSED);
        push_query(KEY_MIN, KEY_MAX);
        push_query(5, 7);
        push_query(7, 5);
        push_query(5, 5);
        push_query(6, 8);
        push_query(-1, 0);
        push_query(KEY_MAX, KEY_MIN);
        push_other(sstq_pkg::OP_CLEAR);
        push_query(KEY_MIN, KEY_MAX);
        push_load(1);
        push_query(1, 2);

        push_random_items(600);
        wait_drained();

        // The receiver holds off while queries keep arriving.
        hold_requests++;
        repeat (60) push_query(pick_key(), pick_key());
        wait_drained();

        // Fill the store to capacity, then offer loads that must be dropped.
        while (gen_values.size() < sstq_pkg::MAX_ENTRIES_DEF)
        begin
            if ($urandom_range(0, 9) == 0)
                push_query(pick_key(), pick_key());
            else
                push_load(pick_value());
        end
        repeat (6) push_load(pick_value());
        push_query(KEY_MIN, KEY_MAX);
        push_query(KEY_MAX, KEY_MAX);
        push_query(KEY_MAX, KEY_MIN);
        repeat (20) push_query(pick_key(), pick_key());
        push_other(sstq_pkg::OP_CLEAR);
        wait_drained();

        quiet = 1'b1;
        push_random_items(300);
        wait_drained();
        repeat (50) @(posedge clk);

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire
